### hw/rtl/gpsc_pkg.sv
// Shared types and constants for the gyro peak step counter.
// No dependencies; every other file of the block uses it by scoped names.
package gpsc_pkg;

  // Default ring depth for pending candidate timestamps
  localparam int unsigned PendingDepthDef = 32;

  // Field widths
  localparam int unsigned GyroW   = 26;
  localparam int unsigned BiasW   = 21;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CountW  = 32;
  localparam int unsigned SmallW  = 6;
  localparam int unsigned AlphaW  = 17;
  localparam int unsigned ThreshW = 26;
  localparam int unsigned MsW     = 16;
  localparam int unsigned FiltW   = 42;
  localparam int unsigned FracW   = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 26;

  // Magnitude: |d| < 2^26 per axis, so the sum of squares fits 54 bits
  localparam int unsigned MagW      = 27;
  localparam int unsigned RadW      = 2 * MagW;
  localparam int unsigned SqrtSteps = MagW;
  localparam int unsigned StepCntW  = 5;

  // Register reset values
  localparam logic [AlphaW-1:0]       AlphaRst  = 17'd22938;
  localparam logic [ThreshW-1:0]      ThreshRst = 26'd800000;
  localparam logic [MsW-1:0]          RefrRst   = 16'd400;
  localparam logic [MsW-1:0]          LagRst    = 16'd2500;
  localparam logic signed [BiasW-1:0] BiasXRst  = 21'sd8512;
  localparam logic signed [BiasW-1:0] BiasYRst  = -21'sd35223;
  localparam logic signed [BiasW-1:0] BiasZRst  = -21'sd726;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLED = 3'd0,
    CFG_ALPHA   = 3'd1,
    CFG_THRESH  = 3'd2,
    CFG_REFR    = 3'd3,
    CFG_LAG     = 3'd4,
    CFG_BIAS_X  = 3'd5,
    CFG_BIAS_Y  = 3'd6,
    CFG_BIAS_Z  = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_SAMPLE   = 2'd0,
    CMD_CLASSIFY = 2'd1,
    CMD_BEGIN    = 2'd2,
    CMD_END      = 2'd3
  } item_cmd_e;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       sq_mul;
    logic [1:0] sq_axis;
    logic       sq_acc;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       first_load;
    logic       ema_diff;
    logic       ema_lo;
    logic       ema_hi;
    logic       ema_sum;
    logic       ema_cur;
    logic       peak_upd;
    logic       cls_set;
    logic       drain_pop;
    logic       drain_all;
    logic       cap_clear;
    logic       cap_on;
    logic       cap_off;
    logic       out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic enabled;
    logic capture_on;
    logic first_sample;
    logic drain_stop;
  } dp_sts_t;

endpackage

### hw/rtl/gpsc_if.sv
// Item channel interfaces for the gyro peak step counter.
// Depends on gpsc_pkg for field widths.
interface gpsc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           cmd;
  logic signed [gpsc_pkg::GyroW-1:0]    gyro_x;
  logic signed [gpsc_pkg::GyroW-1:0]    gyro_y;
  logic signed [gpsc_pkg::GyroW-1:0]    gyro_z;
  logic [gpsc_pkg::TimeW-1:0]           timestamp_ms;
  logic [gpsc_pkg::TimeW-1:0]           window_end_ms;
  logic                                 step_activity;

  modport source (output valid, cmd, gyro_x, gyro_y, gyro_z, timestamp_ms,
                  window_end_ms, step_activity, input ready);
  modport sink (input valid, cmd, gyro_x, gyro_y, gyro_z, timestamp_ms,
                window_end_ms, step_activity, output ready);
endinterface

interface gpsc_out_if;
  logic                          valid;
  logic                          ready;
  logic [gpsc_pkg::SmallW-1:0]   committed;
  logic [gpsc_pkg::CountW-1:0]   total_steps;
  logic [gpsc_pkg::CountW-1:0]   dropped_count;
  logic [gpsc_pkg::SmallW-1:0]   pending_count;
  logic                          candidate_added;
  logic                          capturing;

  modport source (output valid, committed, total_steps, dropped_count, pending_count,
                  candidate_added, capturing, input ready);
  modport sink (input valid, committed, total_steps, dropped_count, pending_count,
                candidate_added, capturing, output ready);
endinterface

### hw/rtl/gpsc_datapath.sv
// Datapath: config registers, magnitude, EMA filter, peak test, pending ring, counters.
// Depends on gpsc_pkg; driven by gpsc_ctrl through dp_cmd_t.
module gpsc_datapath #(
  parameter int unsigned PENDING_DEPTH = gpsc_pkg::PendingDepthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gpsc_pkg::dp_cmd_t                   cmd_i,
  output gpsc_pkg::dp_sts_t                   sts_o,
  input  logic                                cfg_we_i,
  input  logic [gpsc_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [gpsc_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic signed [gpsc_pkg::GyroW-1:0]   gyro_x_i,
  input  logic signed [gpsc_pkg::GyroW-1:0]   gyro_y_i,
  input  logic signed [gpsc_pkg::GyroW-1:0]   gyro_z_i,
  input  logic [gpsc_pkg::TimeW-1:0]          timestamp_ms_i,
  input  logic [gpsc_pkg::TimeW-1:0]          window_end_ms_i,
  input  logic                                step_activity_i,
  output logic [gpsc_pkg::SmallW-1:0]         committed_o,
  output logic [gpsc_pkg::CountW-1:0]         total_steps_o,
  output logic [gpsc_pkg::CountW-1:0]         dropped_count_o,
  output logic [gpsc_pkg::SmallW-1:0]         pending_count_o,
  output logic                                candidate_added_o,
  output logic                                capturing_o
);

  localparam int unsigned PtrW  = $clog2(PENDING_DEPTH);
  localparam int unsigned FillW = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned SumW  = PtrW + 1;
  localparam int unsigned DW    = gpsc_pkg::GyroW + 1;
  localparam int unsigned DiffW = gpsc_pkg::MagW + gpsc_pkg::FracW + 1;
  localparam int unsigned AbsW  = DiffW - 1;
  localparam int unsigned LoW   = 22;
  localparam int unsigned HiW   = AbsW - LoW;
  localparam int unsigned PW    = AbsW + gpsc_pkg::AlphaW + 1;
  localparam int unsigned DeltaW = PW - gpsc_pkg::FracW + 1;
  localparam int unsigned CurW  = DeltaW + 1;
  localparam int unsigned RemW  = gpsc_pkg::MagW + 1;
  localparam logic [gpsc_pkg::FiltW-1:0] FiltMax = '1;

  // Configuration registers
  logic                                enabled_q;
  logic [gpsc_pkg::AlphaW-1:0]         alpha_q;
  logic [gpsc_pkg::ThreshW-1:0]        thresh_q;
  logic [gpsc_pkg::MsW-1:0]            refr_q;
  logic [gpsc_pkg::MsW-1:0]            lag_q;
  logic signed [gpsc_pkg::BiasW-1:0]   bias_x_q, bias_y_q, bias_z_q;

  // Latched item
  logic signed [DW-1:0]                dx_q, dy_q, dz_q;
  logic [gpsc_pkg::TimeW-1:0]          ts_q, we_q;
  logic                                act_q;

  // Magnitude path
  logic [2*gpsc_pkg::GyroW-1:0]        prod_q;
  logic [gpsc_pkg::RadW-1:0]           acc_q, rad_q;
  logic [RemW-1:0]                     rem_q;
  logic [gpsc_pkg::MagW-1:0]           root_q;

  // EMA path
  logic                                neg_q;
  logic [AbsW-1:0]                     dabs_q;
  logic [LoW+gpsc_pkg::AlphaW-1:0]     plo_q;
  logic [HiW+gpsc_pkg::AlphaW-1:0]     phi_q;
  logic signed [DeltaW-1:0]            delta_q;
  logic [gpsc_pkg::FiltW-1:0]          cur_q;

  // Capture state
  logic                                capture_on_q;
  logic [gpsc_pkg::FiltW-1:0]          filt_older_q, filt_last_q;
  logic [gpsc_pkg::TimeW-1:0]          last_sample_q, last_peak_q, cutoff_q;
  logic [1:0]                          seen_q;
  logic                                have_peak_q, have_class_q, last_active_q;
  logic [PtrW-1:0]                     head_q;
  logic [FillW-1:0]                    fill_q;
  logic [gpsc_pkg::CountW-1:0]         total_q, drop_q;
  logic [FillW-1:0]                    commit_q;
  logic                                added_q;

  // Pending ring
  logic [gpsc_pkg::TimeW-1:0]          ring_mem [PENDING_DEPTH];
  logic [gpsc_pkg::TimeW-1:0]          rd_q;

  logic signed [DW-1:0]                sel_d;
  logic [gpsc_pkg::GyroW-1:0]          sel_abs;
  logic [RemW+1:0]                     rem_sh, trial;
  logic signed [DiffW-1:0]             diff;
  logic [PW-1:0]                       psum;
  logic [DeltaW-2:0]                   dmag;
  logic signed [CurW-1:0]              cur;
  logic                                peak, full;
  logic [SumW-1:0]                     wsum;
  logic [PtrW-1:0]                     wr_addr, head_nxt;
  logic [gpsc_pkg::TimeW-1:0]          drain_d;

  // Pick one axis for the shared squarer
  always_comb begin
    case (cmd_i.sq_axis)
      2'd0:    sel_d = dx_q;
      2'd1:    sel_d = dy_q;
      default: sel_d = dz_q;
    endcase
    sel_abs = gpsc_pkg::GyroW'(sel_d < 0 ? -sel_d : sel_d);
  end

  // One square root bit per step
  assign rem_sh = {rem_q, rad_q[gpsc_pkg::RadW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  // EMA arithmetic
  assign diff  = $signed({1'b0, root_q, {gpsc_pkg::FracW{1'b0}}})
               - $signed(DiffW'(filt_last_q));
  assign psum  = PW'(plo_q) + PW'({phi_q, {LoW{1'b0}}});
  assign dmag  = neg_q ? (DeltaW-1)'((psum + PW'(16'hFFFF)) >> gpsc_pkg::FracW)
                       : (DeltaW-1)'(psum >> gpsc_pkg::FracW);
  assign cur   = $signed(CurW'(filt_last_q)) + CurW'(delta_q);

  // Candidate peak on the previous sample
  assign full = (fill_q == FillW'(PENDING_DEPTH));
  assign peak = (seen_q == 2'd2) && (filt_older_q < filt_last_q) && (filt_last_q >= cur_q)
             && (filt_last_q >= {thresh_q, {gpsc_pkg::FracW{1'b0}}})
             && (!have_peak_q || ((last_sample_q - last_peak_q) >= gpsc_pkg::TimeW'(refr_q)));

  // Ring addressing, wrapping at any depth
  assign wsum     = SumW'(head_q) + SumW'(fill_q);
  assign wr_addr  = PtrW'(wsum >= SumW'(PENDING_DEPTH) ? wsum - SumW'(PENDING_DEPTH) : wsum);
  assign head_nxt = (head_q == PtrW'(PENDING_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign drain_d  = rd_q - cutoff_q;

  assign sts_o.enabled      = enabled_q;
  assign sts_o.capture_on   = capture_on_q;
  assign sts_o.first_sample = (seen_q == 2'd0);
  assign sts_o.drain_stop   = (fill_q == '0) ||
                              (!cmd_i.drain_all && !(drain_d == '0 || drain_d[gpsc_pkg::TimeW-1]));

  // Hold configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      alpha_q   <= gpsc_pkg::AlphaRst;
      thresh_q  <= gpsc_pkg::ThreshRst;
      refr_q    <= gpsc_pkg::RefrRst;
      lag_q     <= gpsc_pkg::LagRst;
      bias_x_q  <= gpsc_pkg::BiasXRst;
      bias_y_q  <= gpsc_pkg::BiasYRst;
      bias_z_q  <= gpsc_pkg::BiasZRst;
    end else if (cfg_we_i) begin
      unique case (gpsc_pkg::cfg_idx_e'(cfg_idx_i))
        gpsc_pkg::CFG_ENABLED: enabled_q <= cfg_data_i[0];
        gpsc_pkg::CFG_ALPHA:   alpha_q   <= cfg_data_i[gpsc_pkg::AlphaW-1:0];
        gpsc_pkg::CFG_THRESH:  thresh_q  <= cfg_data_i[gpsc_pkg::ThreshW-1:0];
        gpsc_pkg::CFG_REFR:    refr_q    <= cfg_data_i[gpsc_pkg::MsW-1:0];
        gpsc_pkg::CFG_LAG:     lag_q     <= cfg_data_i[gpsc_pkg::MsW-1:0];
        gpsc_pkg::CFG_BIAS_X:  bias_x_q  <= $signed(cfg_data_i[gpsc_pkg::BiasW-1:0]);
        gpsc_pkg::CFG_BIAS_Y:  bias_y_q  <= $signed(cfg_data_i[gpsc_pkg::BiasW-1:0]);
        gpsc_pkg::CFG_BIAS_Z:  bias_z_q  <= $signed(cfg_data_i[gpsc_pkg::BiasW-1:0]);
        default: ;
      endcase
    end
  end

  // Latch item, square, root and filter (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dx_q  <= DW'(gyro_x_i) - DW'(bias_x_q);
      dy_q  <= DW'(gyro_y_i) - DW'(bias_y_q);
      dz_q  <= DW'(gyro_z_i) - DW'(bias_z_q);
      ts_q  <= timestamp_ms_i;
      we_q  <= window_end_ms_i;
      act_q <= step_activity_i;
      acc_q <= '0;
    end
    if (cmd_i.sq_mul) prod_q <= sel_abs * sel_abs;
    if (cmd_i.sq_acc) acc_q <= acc_q + gpsc_pkg::RadW'(prod_q);
    if (cmd_i.sqrt_init) begin
      rad_q  <= acc_q;
      rem_q  <= '0;
      root_q <= '0;
    end
    if (cmd_i.sqrt_step) begin
      rad_q <= rad_q << 2;
      if (rem_sh >= trial) begin
        rem_q  <= RemW'(rem_sh - trial);
        root_q <= {root_q[gpsc_pkg::MagW-2:0], 1'b1};
      end else begin
        rem_q  <= RemW'(rem_sh);
        root_q <= {root_q[gpsc_pkg::MagW-2:0], 1'b0};
      end
    end
    if (cmd_i.ema_diff) begin
      neg_q  <= diff < 0;
      dabs_q <= AbsW'(diff < 0 ? -diff : diff);
    end
    if (cmd_i.ema_lo) plo_q <= dabs_q[LoW-1:0] * alpha_q;
    if (cmd_i.ema_hi) phi_q <= dabs_q[AbsW-1:LoW] * alpha_q;
    if (cmd_i.ema_sum) delta_q <= neg_q ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
    if (cmd_i.ema_cur) begin
      if (cur < 0) cur_q <= '0;
      else if (cur > $signed(CurW'(FiltMax))) cur_q <= FiltMax;
      else cur_q <= gpsc_pkg::FiltW'(cur);
    end
    if (cmd_i.cls_set) begin
      cutoff_q <= (we_q >= gpsc_pkg::TimeW'(lag_q)) ? we_q - gpsc_pkg::TimeW'(lag_q) : '0;
    end
  end

  // Advance capture state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capture_on_q  <= 1'b0;
      filt_older_q  <= '0;
      filt_last_q   <= '0;
      last_sample_q <= '0;
      last_peak_q   <= '0;
      seen_q        <= '0;
      have_peak_q   <= 1'b0;
      have_class_q  <= 1'b0;
      last_active_q <= 1'b0;
      head_q        <= '0;
      fill_q        <= '0;
      total_q       <= '0;
      drop_q        <= '0;
      commit_q      <= '0;
      added_q       <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        commit_q <= '0;
        added_q  <= 1'b0;
      end
      if (cmd_i.first_load) begin
        filt_last_q   <= gpsc_pkg::FiltW'({root_q, {gpsc_pkg::FracW{1'b0}}});
        last_sample_q <= ts_q;
        seen_q        <= 2'd1;
      end
      if (cmd_i.peak_upd) begin
        if (peak) begin
          if (full) drop_q <= drop_q + 1'b1;
          else fill_q <= fill_q + 1'b1;
          last_peak_q <= last_sample_q;
          have_peak_q <= 1'b1;
          added_q     <= 1'b1;
        end
        filt_older_q  <= filt_last_q;
        filt_last_q   <= cur_q;
        last_sample_q <= ts_q;
        if (seen_q != 2'd2) seen_q <= seen_q + 1'b1;
      end
      if (cmd_i.cls_set) begin
        have_class_q  <= 1'b1;
        last_active_q <= act_q;
      end
      if (cmd_i.drain_pop) begin
        head_q <= head_nxt;
        fill_q <= fill_q - 1'b1;
        if (have_class_q && last_active_q) begin
          commit_q <= commit_q + 1'b1;
          if (total_q != '1) total_q <= total_q + 1'b1;
        end
      end
      if (cmd_i.cap_clear) begin
        filt_older_q  <= '0;
        filt_last_q   <= '0;
        last_sample_q <= '0;
        last_peak_q   <= '0;
        seen_q        <= '0;
        have_peak_q   <= 1'b0;
        have_class_q  <= 1'b0;
        last_active_q <= 1'b0;
        head_q        <= '0;
        fill_q        <= '0;
      end
      if (cmd_i.cap_on) capture_on_q <= 1'b1;
      if (cmd_i.cap_off) capture_on_q <= 1'b0;
    end
  end

  // Ring storage: push at tail, registered read at head
  always_ff @(posedge clk_i) begin
    if (cmd_i.peak_upd && peak && !full) ring_mem[wr_addr] <= last_sample_q;
    rd_q <= ring_mem[head_q];
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      committed_o       <= (32'(commit_q) > 32'd63) ? 6'd63 : gpsc_pkg::SmallW'(commit_q);
      total_steps_o     <= total_q;
      dropped_count_o   <= drop_q;
      pending_count_o   <= gpsc_pkg::SmallW'(fill_q);
      candidate_added_o <= added_q;
      capturing_o       <= capture_on_q;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(PENDING_DEPTH))
    else $error("pending fill above ring depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.drain_pop |-> fill_q != '0)
    else $error("pop from empty ring");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.peak_upd && peak && !full) |=> fill_q != '0)
    else $error("push left ring empty");

endmodule

### hw/rtl/gpsc_ctrl.sv
// Controller: sequences one item through the datapath and owns the handshakes.
// Depends on gpsc_pkg for command and status structs.
module gpsc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         in_cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  gpsc_pkg::dp_sts_t  sts_i,
  output gpsc_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_SQRT_INIT, ST_SQRT, ST_FIRST, ST_EMA_DIFF, ST_EMA_LO,
    ST_EMA_HI, ST_EMA_SUM, ST_EMA_CUR, ST_PEAK, ST_CLS, ST_DRAIN_RD, ST_DRAIN_CHK,
    ST_CLR, ST_FINISH
  } state_e;

  state_e                            state_q;
  gpsc_pkg::item_cmd_e               icmd_q;
  logic [gpsc_pkg::StepCntW-1:0]     cnt_q;
  logic                              out_valid_q;
  logic                              accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  // Decode datapath commands from state
  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = accept;
    cmd_o.sq_axis   = cnt_q[1:0];
    cmd_o.drain_all = (icmd_q != gpsc_pkg::CMD_CLASSIFY);
    unique case (state_q)
      ST_SQ: begin
        cmd_o.sq_mul = (cnt_q != gpsc_pkg::StepCntW'(3));
        cmd_o.sq_acc = (cnt_q != '0);
      end
      ST_SQRT_INIT: cmd_o.sqrt_init = 1'b1;
      ST_SQRT:      cmd_o.sqrt_step = 1'b1;
      ST_FIRST:     cmd_o.first_load = 1'b1;
      ST_EMA_DIFF:  cmd_o.ema_diff = 1'b1;
      ST_EMA_LO:    cmd_o.ema_lo = 1'b1;
      ST_EMA_HI:    cmd_o.ema_hi = 1'b1;
      ST_EMA_SUM:   cmd_o.ema_sum = 1'b1;
      ST_EMA_CUR:   cmd_o.ema_cur = 1'b1;
      ST_PEAK:      cmd_o.peak_upd = 1'b1;
      ST_CLS:       cmd_o.cls_set = 1'b1;
      ST_DRAIN_CHK: cmd_o.drain_pop = !sts_i.drain_stop;
      ST_CLR: begin
        cmd_o.cap_clear = 1'b1;
        cmd_o.cap_on    = (icmd_q == gpsc_pkg::CMD_BEGIN);
        cmd_o.cap_off   = (icmd_q == gpsc_pkg::CMD_END);
      end
      ST_FINISH:    cmd_o.out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // Hold state, step counter and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      icmd_q      <= gpsc_pkg::CMD_SAMPLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            icmd_q <= gpsc_pkg::item_cmd_e'(in_cmd_i);
            cnt_q  <= '0;
            if (!sts_i.enabled) state_q <= ST_FINISH;
            else if (gpsc_pkg::item_cmd_e'(in_cmd_i) == gpsc_pkg::CMD_BEGIN)
              state_q <= sts_i.capture_on ? ST_DRAIN_RD : ST_CLR;
            else if (!sts_i.capture_on) state_q <= ST_FINISH;
            else begin
              unique case (gpsc_pkg::item_cmd_e'(in_cmd_i))
                gpsc_pkg::CMD_SAMPLE:   state_q <= ST_SQ;
                gpsc_pkg::CMD_CLASSIFY: state_q <= ST_CLS;
                default:                state_q <= ST_DRAIN_RD;
              endcase
            end
          end
        end
        ST_SQ: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == gpsc_pkg::StepCntW'(3)) state_q <= ST_SQRT_INIT;
        end
        ST_SQRT_INIT: begin
          cnt_q   <= '0;
          state_q <= ST_SQRT;
        end
        ST_SQRT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == gpsc_pkg::StepCntW'(gpsc_pkg::SqrtSteps - 1))
            state_q <= sts_i.first_sample ? ST_FIRST : ST_EMA_DIFF;
        end
        ST_FIRST:    state_q <= ST_FINISH;
        ST_EMA_DIFF: state_q <= ST_EMA_LO;
        ST_EMA_LO:   state_q <= ST_EMA_HI;
        ST_EMA_HI:   state_q <= ST_EMA_SUM;
        ST_EMA_SUM:  state_q <= ST_EMA_CUR;
        ST_EMA_CUR:  state_q <= ST_PEAK;
        ST_PEAK:     state_q <= ST_FINISH;
        ST_CLS:      state_q <= ST_DRAIN_RD;
        ST_DRAIN_RD: state_q <= ST_DRAIN_CHK;
        ST_DRAIN_CHK: begin
          if (!sts_i.drain_stop) state_q <= ST_DRAIN_RD;
          else if (icmd_q == gpsc_pkg::CMD_CLASSIFY) state_q <= ST_FINISH;
          else state_q <= ST_CLR;
        end
        ST_CLR: state_q <= ST_FINISH;
        ST_FINISH: begin
          if (cmd_o.out_load) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ST_IDLE)
    else $error("accepted item did not start");

  a_result_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before taken");

  a_pop_only_draining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.drain_pop |-> $past(state_q) == ST_DRAIN_RD)
    else $error("pop without fresh ring read");

endmodule

### hw/rtl/gyro_peak_step_counter_unit.sv
// Top level of the gyro peak step counter: controller plus datapath.
// Depends on gpsc_pkg, gpsc_if, gpsc_ctrl and gpsc_datapath.
//
// One item in, one result out. Items are processed one at a time; a finished
// result waits in an output register, so the next item is accepted while it is
// held. A sample passes the shared axis squarer, the bit-serial square root (one
// result bit per cycle), then the split EMA multiply and peak test. Classify and
// end capture drain the ring entry by entry (registered ring read, then test and
// pop). Disabled or idle-capture items go straight to the result. Configuration
// writes land on the next clock edge; the user must make them between items, as
// the block itself does not enforce it.
module gyro_peak_step_counter_unit #(
  parameter int unsigned PENDING_DEPTH = gpsc_pkg::PendingDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  gpsc_in_if.sink                        item_in,
  gpsc_out_if.source                     item_out,
  input  logic                           cfg_we_i,
  input  logic [gpsc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [gpsc_pkg::CfgDataW-1:0]  cfg_data_i
);

  gpsc_pkg::dp_cmd_t dp_cmd;
  gpsc_pkg::dp_sts_t dp_sts;

  gpsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_in.valid),
    .in_ready_o  (item_in.ready),
    .in_cmd_i    (item_in.cmd),
    .out_valid_o (item_out.valid),
    .out_ready_i (item_out.ready),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  gpsc_datapath #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (dp_cmd),
    .sts_o             (dp_sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .gyro_x_i          (item_in.gyro_x),
    .gyro_y_i          (item_in.gyro_y),
    .gyro_z_i          (item_in.gyro_z),
    .timestamp_ms_i    (item_in.timestamp_ms),
    .window_end_ms_i   (item_in.window_end_ms),
    .step_activity_i   (item_in.step_activity),
    .committed_o       (item_out.committed),
    .total_steps_o     (item_out.total_steps),
    .dropped_count_o   (item_out.dropped_count),
    .pending_count_o   (item_out.pending_count),
    .candidate_added_o (item_out.candidate_added),
    .capturing_o       (item_out.capturing)
  );

endmodule

### verif/tb_gyro_peak_step_counter_unit.sv
// Self-checking testbench for gyro_peak_step_counter_unit: random and directed items
// are checked against an in-bench predictor of the step counter.
// Depends on gpsc_pkg, gpsc_if and the RTL of the block.
`timescale 1ns / 100ps

module tb_gyro_peak_step_counter_unit;

  typedef struct {
    gpsc_pkg::item_cmd_e cmd;
    logic signed [25:0]  gx, gy, gz;
    logic [31:0]         ts;
    logic [31:0]         win_end;
    logic                active;
  } step_item_t;

  typedef struct {
    logic [5:0]  committed;
    logic [31:0] total;
    logic [31:0] dropped;
    logic [5:0]  pending;
    logic        added;
    logic        capturing;
  } step_result_t;

  localparam longint unsigned FiltMax = (64'd1 << 42) - 1;
  localparam int RegSettle = 100;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [gpsc_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [gpsc_pkg::CfgDataW-1:0] cfg_data_i;

  gpsc_in_if  in_ch ();
  gpsc_out_if out_ch ();

  gyro_peak_step_counter_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_in    (in_ch),
    .item_out   (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Predictor configuration
  logic               p_en;
  logic [16:0]        p_alpha;
  logic [25:0]        p_thresh;
  logic [15:0]        p_refr, p_lag;
  logic signed [20:0] p_bias_x, p_bias_y, p_bias_z;

  // Predictor state
  logic        cap_on, class_seen, class_active, peak_valid;
  logic [41:0] flt_older, flt_last;
  logic [31:0] prev_ts, peak_ts, step_sum, drop_sum;
  int          seen_cnt;
  logic [31:0] ts_ring [32];
  logic [4:0]  rd_ptr;
  int          ring_cnt;

  step_result_t expected_q[$];
  int  n_sent, n_checked, n_errors, n_peaks, n_steps_seen;
  bit  src_idle_on, snk_idle_on;

  // Floor square root, one result bit at a time
  function automatic logic [26:0] floor_root(longint unsigned v);
    logic [26:0] r;
    longint unsigned t;
    r = '0;
    for (int i = 26; i >= 0; i--) begin
      t = longint'(r) | (64'd1 << i);
      if (t * t <= v) r = t[26:0];
    end
    return r;
  endfunction

  function automatic void clear_session();
    flt_older = '0; flt_last = '0; prev_ts = '0; seen_cnt = 0;
    peak_ts = '0; peak_valid = 0; rd_ptr = '0; ring_cnt = 0;
    class_seen = 0; class_active = 0;
  endfunction

  // Pop ring entries at or before the cutoff (or all), optionally counting them
  function automatic int pop_ring(bit all, logic [31:0] cutoff, bit count);
    int n;
    logic [31:0] d;
    n = 0;
    while (ring_cnt > 0) begin
      d = ts_ring[rd_ptr] - cutoff;
      if (!all && !(d == 0 || d[31])) break;
      if (count) begin
        if (step_sum != 32'hFFFF_FFFF) step_sum++;
        n++;
      end
      rd_ptr++;
      ring_cnt--;
    end
    return n;
  endfunction

  function automatic int close_session();
    int n;
    n = pop_ring(1, '0, class_seen && class_active);
    cap_on = 0;
    clear_session();
    return n;
  endfunction

  function automatic bit take_sample(step_item_t it);
    longint dx, dy, dz, prev, p, cur;
    logic [26:0] mag;
    logic [31:0] gap;
    logic [41:0] curu;
    bit added;
    dx = longint'(it.gx) - longint'(p_bias_x);
    dy = longint'(it.gy) - longint'(p_bias_y);
    dz = longint'(it.gz) - longint'(p_bias_z);
    mag = floor_root(dx * dx + dy * dy + dz * dz);
    added = 0;
    if (seen_cnt == 0) begin
      flt_last = (longint'(mag) << 16) & FiltMax;
      prev_ts = it.ts;
      seen_cnt = 1;
      return 0;
    end
    prev = longint'(flt_last);
    p = ((longint'(mag) << 16) - prev) * longint'(p_alpha);
    cur = prev + (p >>> 16);
    if (cur < 0) cur = 0;
    if (cur > longint'(FiltMax)) cur = longint'(FiltMax);
    curu = cur[41:0];
    gap = prev_ts - peak_ts;
    if (seen_cnt >= 2 && flt_older < flt_last && flt_last >= curu &&
        flt_last >= {p_thresh, 16'd0} && (!peak_valid || gap >= p_refr)) begin
      if (ring_cnt >= 32) drop_sum++;
      else begin
        ts_ring[5'(rd_ptr + ring_cnt)] = prev_ts;
        ring_cnt++;
      end
      peak_ts = prev_ts;
      peak_valid = 1;
      added = 1;
    end
    flt_older = flt_last;
    flt_last = curu;
    prev_ts = it.ts;
    if (seen_cnt < 2) seen_cnt++;
    return added;
  endfunction

  // Expected result of one item; advances the predictor state
  function automatic step_result_t predict_step(step_item_t it);
    step_result_t r;
    int n;
    bit added;
    logic [31:0] cutoff;
    n = 0;
    added = 0;
    if (p_en) begin
      if (it.cmd == gpsc_pkg::CMD_BEGIN) begin
        if (cap_on) n = close_session();
        clear_session();
        cap_on = 1;
      end else if (cap_on) begin
        case (it.cmd)
          gpsc_pkg::CMD_SAMPLE: added = take_sample(it);
          gpsc_pkg::CMD_CLASSIFY: begin
            cutoff = (it.win_end >= p_lag) ? it.win_end - p_lag : '0;
            class_seen = 1;
            class_active = it.active;
            n = pop_ring(0, cutoff, it.active);
          end
          default: n = close_session();
        endcase
      end
    end
    if (n > 63) n = 63;
    r.committed = 6'(n);
    r.total = step_sum;
    r.dropped = drop_sum;
    r.pending = 6'(ring_cnt);
    r.added = added;
    r.capturing = cap_on;
    if (added) n_peaks++;
    return r;
  endfunction

  // Send one item and queue its expected result on acceptance
  task automatic send_item(step_item_t it);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.cmd <= it.cmd;
    in_ch.gyro_x <= it.gx;
    in_ch.gyro_y <= it.gy;
    in_ch.gyro_z <= it.gz;
    in_ch.timestamp_ms <= it.ts;
    in_ch.window_end_ms <= it.win_end;
    in_ch.step_activity <= it.active;
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_q.push_back(predict_step(it));
    n_sent++;
  endtask

  // Hold input and wait until every result is back and the block is quiet
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (RegSettle) @(posedge clk_i);
  endtask

  task automatic write_reg(gpsc_pkg::cfg_idx_e idx, logic [25:0] val);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      gpsc_pkg::CFG_ENABLED: p_en = val[0];
      gpsc_pkg::CFG_ALPHA:   p_alpha = val[16:0];
      gpsc_pkg::CFG_THRESH:  p_thresh = val[25:0];
      gpsc_pkg::CFG_REFR:    p_refr = val[15:0];
      gpsc_pkg::CFG_LAG:     p_lag = val[15:0];
      gpsc_pkg::CFG_BIAS_X:  p_bias_x = val[20:0];
      gpsc_pkg::CFG_BIAS_Y:  p_bias_y = val[20:0];
      default:               p_bias_z = val[20:0];
    endcase
  endtask

  function automatic step_item_t make_item(gpsc_pkg::item_cmd_e c, longint x, longint y,
                                           longint z, logic [31:0] ts, logic [31:0] we,
                                           logic act);
    step_item_t it;
    it.cmd = c; it.gx = 26'(x); it.gy = 26'(y); it.gz = 26'(z);
    it.ts = ts; it.win_end = we; it.active = act;
    return it;
  endfunction

  function automatic step_item_t noise_item();
    return make_item(gpsc_pkg::item_cmd_e'($urandom_range(0, 3)), $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom_range(0, 1));
  endfunction

  function automatic longint clip26(longint v);
    if (v > 33554431) return 33554431;
    if (v < -33554432) return -33554432;
    return v;
  endfunction

  // Items while disabled must leave everything untouched
  task automatic test_disabled();
    for (int i = 0; i < 8; i++) send_item(noise_item());
    send_item(make_item(gpsc_pkg::CMD_BEGIN, 0, 0, 0, 0, 0, 0));
    write_reg(gpsc_pkg::CFG_ENABLED, 26'd1);
  endtask

  // Field extremes, every command, and the documented corner cases
  task automatic test_directed();
    send_item(make_item(gpsc_pkg::CMD_SAMPLE, 100, 0, 0, 5, 0, 0));
    send_item(make_item(gpsc_pkg::CMD_CLASSIFY, 0, 0, 0, 0, 32'd9000, 1));
    send_item(make_item(gpsc_pkg::CMD_END, 0, 0, 0, 0, 0, 0));
    send_item(make_item(gpsc_pkg::CMD_BEGIN, 0, 0, 0, 0, 0, 0));
    send_item(make_item(gpsc_pkg::CMD_SAMPLE, 33554431, 33554431, 33554431,
                        32'hFFFF_FF00, 0, 0));
    send_item(make_item(gpsc_pkg::CMD_SAMPLE, -33554432, -33554432, -33554432,
                        32'hFFFF_FFF0, 0, 0));
    send_item(make_item(gpsc_pkg::CMD_SAMPLE, 0, 0, 0, 32'h0000_0100, 0, 0));
    send_item(make_item(gpsc_pkg::CMD_SAMPLE, 8512, -35223, -726, 32'h0000_0400, 0, 0));
    // Rising then falling magnitude to form a peak
    for (int i = 0; i < 6; i++)
      send_item(make_item(gpsc_pkg::CMD_SAMPLE, (i < 3 ? i : 6 - i) * 4000000, 0, 0,
                          32'h0000_0800 + i * 600, 0, 0));
    send_item(make_item(gpsc_pkg::CMD_CLASSIFY, 0, 0, 0, 0, 32'd100, 1));
    send_item(make_item(gpsc_pkg::CMD_CLASSIFY, 0, 0, 0, 0, 32'hFFFF_FFFF, 1));
    send_item(make_item(gpsc_pkg::CMD_BEGIN, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 5; i++)
      send_item(make_item(gpsc_pkg::CMD_SAMPLE, 0, (i == 2) ? 9000000 : 0, 0, i * 500,
                          0, 0));
    send_item(make_item(gpsc_pkg::CMD_BEGIN, 0, 0, 0, 0, 0, 0));
    send_item(make_item(gpsc_pkg::CMD_END, 0, 0, 0, 0, 0, 0));
  endtask

  // One capture with a periodic magnitude and random classify windows
  task automatic run_session(int n, int amp, int cls_pct);
    logic [31:0] ts;
    int k, lvl, roll;
    ts = ($urandom_range(0, 3) == 0) ? 32'hFFFF_F000 + $urandom_range(0, 4000) : $urandom;
    k = $urandom_range(0, 5);
    send_item(make_item(gpsc_pkg::CMD_BEGIN, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) send_item(noise_item());
      else if (roll < 5 + cls_pct)
        send_item(make_item(gpsc_pkg::CMD_CLASSIFY, 0, 0, 0, 0,
                            ts + $urandom_range(0, 6000) - 32'd3000,
                            $urandom_range(0, 3) != 0));
      else if (roll == 99) begin
        send_item(make_item(gpsc_pkg::CMD_END, 0, 0, 0, 0, 0, 0));
        send_item(make_item(gpsc_pkg::CMD_BEGIN, 0, 0, 0, 0, 0, 0));
      end else begin
        k++;
        lvl = (k % 6 < 3) ? k % 6 : 6 - k % 6;
        ts += $urandom_range(5, 150);
        send_item(make_item(gpsc_pkg::CMD_SAMPLE,
                            clip26(longint'(lvl) * amp + longint'(p_bias_x)
                                   + longint'($urandom_range(0, 2000))),
                            clip26(longint'(p_bias_y) - $urandom_range(0, 2000)),
                            clip26(longint'(p_bias_z) + longint'(lvl) * amp / 4),
                            ts, 0, 0));
      end
      if (i % 40 == 0) begin
        src_idle_on = $urandom_range(0, 2) != 0;
        snk_idle_on = $urandom_range(0, 2) != 0;
      end
    end
  endtask

  // Random phases under several register settings, extremes included
  task automatic test_random();
    int amp;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(gpsc_pkg::CFG_THRESH, 26'd200000); write_reg(gpsc_pkg::CFG_REFR, 16'd0);
        end
        1: begin
          write_reg(gpsc_pkg::CFG_ALPHA, 26'd65536); write_reg(gpsc_pkg::CFG_LAG, 26'd0);
          write_reg(gpsc_pkg::CFG_BIAS_X, 26'h0F_FFFF);
          write_reg(gpsc_pkg::CFG_BIAS_Y, 26'h10_0000);
          write_reg(gpsc_pkg::CFG_BIAS_Z, 26'h1F_FFFF);
        end
        2: begin
          write_reg(gpsc_pkg::CFG_ALPHA, 26'd131071); write_reg(gpsc_pkg::CFG_THRESH, 26'd0);
          write_reg(gpsc_pkg::CFG_LAG, 26'hFFFF); write_reg(gpsc_pkg::CFG_REFR, 26'hFFFF);
        end
        3: begin
          write_reg(gpsc_pkg::CFG_ALPHA, 26'd0);
          write_reg(gpsc_pkg::CFG_THRESH, 26'h3FF_FFFF);
          write_reg(gpsc_pkg::CFG_REFR, 26'd200);
        end
        4: begin
          write_reg(gpsc_pkg::CFG_ALPHA, 26'($urandom_range(20000, 65536)));
          write_reg(gpsc_pkg::CFG_THRESH, 26'($urandom_range(10000, 3000000)));
          write_reg(gpsc_pkg::CFG_REFR, 26'($urandom_range(0, 300)));
          write_reg(gpsc_pkg::CFG_LAG, 26'($urandom_range(0, 3000)));
          write_reg(gpsc_pkg::CFG_BIAS_X, 26'($urandom));
          write_reg(gpsc_pkg::CFG_BIAS_Y, 26'($urandom));
          write_reg(gpsc_pkg::CFG_BIAS_Z, 26'($urandom));
        end
        default: begin
          write_reg(gpsc_pkg::CFG_ALPHA, 26'd40000); write_reg(gpsc_pkg::CFG_THRESH, 26'd500000);
          write_reg(gpsc_pkg::CFG_REFR, 26'd100); write_reg(gpsc_pkg::CFG_LAG, 26'd1000);
        end
      endcase
      while (n_sent < 60 + (ph + 1) * 300) begin
        amp = (p_thresh == 0) ? $urandom_range(0, 4000000)
                              : $urandom_range(p_thresh / 3, p_thresh / 3 + p_thresh);
        if (amp > 11000000 || amp < 0) amp = $urandom_range(5000000, 11000000);
        run_session($urandom_range(20, 120), amp, ($urandom_range(0, 2) == 0) ? 1 : 10);
      end
    end
    write_reg(gpsc_pkg::CFG_ENABLED, 26'd0);
    for (int i = 0; i < 10; i++) send_item(noise_item());
  endtask

  // Result side: random stall before each result
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = snk_idle_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    step_result_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result with nothing pending");
        n_errors++;
      end else begin
        e = expected_q.pop_front();
        n_checked++;
        n_steps_seen += out_ch.committed;
        if (out_ch.committed !== e.committed) begin
          $error("committed: expected %0d actual %0d", e.committed, out_ch.committed);
          n_errors++;
        end
        if (out_ch.total_steps !== e.total) begin
          $error("total_steps: expected %0d actual %0d", e.total, out_ch.total_steps);
          n_errors++;
        end
        if (out_ch.dropped_count !== e.dropped) begin
          $error("dropped_count: expected %0d actual %0d", e.dropped, out_ch.dropped_count);
          n_errors++;
        end
        if (out_ch.pending_count !== e.pending) begin
          $error("pending_count: expected %0d actual %0d", e.pending, out_ch.pending_count);
          n_errors++;
        end
        if (out_ch.candidate_added !== e.added) begin
          $error("candidate_added: expected %0d actual %0d", e.added,
                 out_ch.candidate_added);
          n_errors++;
        end
        if (out_ch.capturing !== e.capturing) begin
          $error("capturing: expected %0d actual %0d", e.capturing, out_ch.capturing);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #6_000_000;
    $display("Timeout waiting for the block");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = gpsc_pkg::CMD_SAMPLE;
    in_ch.gyro_x = '0; in_ch.gyro_y = '0; in_ch.gyro_z = '0;
    in_ch.timestamp_ms = '0; in_ch.window_end_ms = '0; in_ch.step_activity = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = gpsc_pkg::CFG_ENABLED; cfg_data_i = '0;
    p_en = 0; p_alpha = gpsc_pkg::AlphaRst; p_thresh = gpsc_pkg::ThreshRst;
    p_refr = gpsc_pkg::RefrRst; p_lag = gpsc_pkg::LagRst;
    p_bias_x = gpsc_pkg::BiasXRst; p_bias_y = gpsc_pkg::BiasYRst;
    p_bias_z = gpsc_pkg::BiasZRst;
    cap_on = 0; step_sum = '0; drop_sum = '0;
    clear_session();
    n_sent = 0; n_checked = 0; n_errors = 0; n_peaks = 0; n_steps_seen = 0;
    src_idle_on = 1; snk_idle_on = 1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_disabled();
    test_directed();
    test_random();
    wait_idle();

    $display("Covered %0d items, %0d results checked, %0d candidate peaks, %0d steps",
             n_sent, n_checked, n_peaks, n_steps_seen);
    $display("Final totals: steps %0d, dropped %0d", step_sum, drop_sum);
    if (n_errors == 0 && expected_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### files.f
hw/rtl/gpsc_pkg.sv
hw/rtl/gpsc_if.sv
hw/rtl/gpsc_datapath.sv
hw/rtl/gpsc_ctrl.sv
hw/rtl/gyro_peak_step_counter_unit.sv
verif/tb_gyro_peak_step_counter_unit.sv
